>>> hdl/ogh_pkg.sv
// ogh_pkg: shared types, register indexes and the window rule of the
// half-scale occupancy grid block. No dependencies.
package ogh_pkg;

  localparam int MaxWidthDefault = 4096;
  localparam int FifoDepth       = 2;

  // configuration register indexes
  localparam logic [2:0] CfgGridWidth   = 3'd0;
  localparam logic [2:0] CfgGridHeight  = 3'd1;
  localparam logic [2:0] CfgLethalCode  = 3'd2;
  localparam logic [2:0] CfgFreeCode    = 3'd3;
  localparam logic [2:0] CfgUnknownCode = 3'd4;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_STORE,
    OP_LEFT,
    OP_EMIT
  } cmd_op_e;

  // one classified input cell on its way from front to back
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] cost;
    logic       bank_odd;
    logic       row_end;
    logic       frame_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] lethal;
    logic [7:0] free;
    logic [7:0] unknown;
  } codes_t;

  function automatic logic [7:0] window_cost(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d,
                                             input codes_t codes);
    logic [7:0] res;
    if (a == codes.lethal || b == codes.lethal || c == codes.lethal || d == codes.lethal) begin
      res = codes.lethal;
    end else if (a == codes.free || b == codes.free || c == codes.free ||
                 d == codes.free) begin
      res = codes.free;
    end else if (a == codes.unknown && b == codes.unknown && c == codes.unknown &&
                 d == codes.unknown) begin
      res = codes.unknown;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

>>> hdl/occupancy_grid_half_scale.sv
// occupancy_grid_half_scale: 2x2 downsampling of a raster-order occupancy grid
// results pass the command queue, then the window registers, then the output register
// one cell per cycle unless the queue is full; queue and output register absorb stalls
// reset: counters, left cell and handshake state clear; registers take their defaults,
// line buffer contents stay undefined until written. depends on ogh_pkg
module occupancy_grid_half_scale import ogh_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault,
  localparam int ColW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2,
  localparam int AddrW = ColW - 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cell input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cell_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  down_cost_o,
  output logic        row_end_o,
  output logic        frame_end_o,
  // register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CmdW = $bits(cmd_t) + AddrW;

  // configuration registers
  logic [12:0] grid_width_q;
  logic [15:0] grid_height_q;
  codes_t      codes_q;

  // front to queue
  logic             push, full;
  cmd_t             front_cmd;
  logic [AddrW-1:0] front_addr;
  logic [CmdW-1:0]  push_data, pop_data;

  // queue to back
  logic             fifo_valid, pop;
  cmd_t             back_cmd;
  logic [AddrW-1:0] back_addr;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= 13'd4096;
      grid_height_q   <= 16'd4096;
      codes_q.lethal  <= 8'd254;
      codes_q.free    <= 8'd0;
      codes_q.unknown <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgGridWidth:   grid_width_q    <= cfg_data_i[12:0];
        CfgGridHeight:  grid_height_q   <= cfg_data_i;
        CfgLethalCode:  codes_q.lethal  <= cfg_data_i[7:0];
        CfgFreeCode:    codes_q.free    <= cfg_data_i[7:0];
        CfgUnknownCode: codes_q.unknown <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input is held off only when the command queue is full
  assign in_stall_o = full;

  // front: counts columns and rows and sorts each cell into store, left, window or skip
  ogh_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .full_i        (full),
    .cell_in_i     (cell_in_i),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .addr_o        (front_addr)
  );

  assign push_data = {front_cmd, front_addr};

  // short queue, lets the front keep taking cells while the back waits on the output
  ogh_fifo #(
    .DW    (CmdW),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .full_o      (full),
    .pop_data_o  (pop_data)
  );

  assign back_cmd  = pop_data[CmdW-1:AddrW];
  assign back_addr = pop_data[AddrW-1:0];

  // back: line buffer write and read, window rule, output register
  ogh_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (back_cmd),
    .addr_i      (back_addr),
    .pop_o       (pop),
    .codes_i     (codes_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .down_cost_o (down_cost_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

>>> hdl/ogh_front.sv
// ogh_front: raster counters and cell classification for the half-scale grid.
// Depends on ogh_pkg.
module ogh_front import ogh_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault,
  localparam int ColW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2,
  localparam int AddrW = ColW - 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             full_i,
  input  logic [7:0]       cell_in_i,
  input  logic [12:0]      grid_width_i,
  input  logic [15:0]      grid_height_i,
  output logic             push_o,
  output cmd_t             cmd_o,
  output logic [AddrW-1:0] addr_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [31:0]     w_sat;
  logic [ColW:0]   w_eff, last_out_col, col_ext;
  logic [15:0]     h_eff, last_out_row;
  logic            accept, line_end, last_row, re;

  always_comb begin
    if (grid_width_i < 13'd2) begin
      w_sat = 32'd2;
    end else if (32'(grid_width_i) > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end else begin
      w_sat = 32'(grid_width_i);
    end
  end

  assign w_eff        = w_sat[ColW:0];
  assign h_eff        = (grid_height_i < 16'd2) ? 16'd2 : grid_height_i;
  assign col_ext      = {1'b0, col_q};
  assign last_out_col = {w_eff[ColW:1], 1'b0} - {{ColW{1'b0}}, 1'b1};
  assign last_out_row = {h_eff[15:1], 1'b0} - 16'd1;
  assign line_end     = col_ext >= (w_eff - {{ColW{1'b0}}, 1'b1});
  assign last_row     = row_q >= (h_eff - 16'd1);
  assign re           = col_ext == last_out_col;
  assign accept       = in_valid_i && !full_i;

  always_comb begin
    cmd_o.cost      = cell_in_i;
    cmd_o.bank_odd  = col_q[0];
    cmd_o.row_end   = re;
    cmd_o.frame_end = re && (row_q == last_out_row);
    if (!row_q[0]) begin
      cmd_o.op = OP_STORE;
    end else if (!col_q[0]) begin
      cmd_o.op = OP_LEFT;
    end else if (col_ext < w_eff) begin
      cmd_o.op = OP_EMIT;
    end else begin
      cmd_o.op = OP_SKIP;
    end
  end

  assign addr_o = col_q[ColW-1:1];
  assign push_o = accept && (cmd_o.op != OP_SKIP);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (line_end) begin
        col_d = '0;
        row_d = last_row ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + {{(ColW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hdl/ogh_fifo.sv
// ogh_fifo: short command queue between front and back.
// Depends on ogh_pkg for its default depth.
module ogh_fifo import ogh_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = FifoDepth,
  localparam int PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign valid_o    = cnt_q != '0;
  assign full_o     = cnt_q == (PtrW+1)'(DEPTH);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + {{PtrW{1'b0}}, 1'b1};
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - {{PtrW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/ogh_back.sv
// ogh_back: line buffer banks, left cell, window evaluation and output register.
// Depends on ogh_pkg.
module ogh_back import ogh_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault,
  localparam int ColW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2,
  localparam int AddrW = ColW - 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             pop_o,
  input  codes_t           codes_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       down_cost_o,
  output logic             row_end_o,
  output logic             frame_end_o
);

  // even and odd columns of even rows live in separate banks
  logic [7:0] bank_even_q [2**AddrW];
  logic [7:0] bank_odd_q  [2**AddrW];

  logic [7:0] left_q;
  logic [7:0] tl_q, tr_q, bl_q, br_q;
  logic       s1_re_q, s1_fe_q;
  logic       s1_v_q, s1_v_d, out_v_q, out_v_d;
  logic [7:0] cost_q;
  logic       re_q, fe_q;
  logic       out_free, s1_free, is_emit, do_emit, do_store, do_left;

  assign out_free = !out_v_q || !out_stall_i;
  assign s1_free  = !s1_v_q || out_free;
  assign is_emit  = cmd_i.op == OP_EMIT;
  assign pop_o    = cmd_valid_i && (!is_emit || s1_free);
  assign do_emit  = pop_o && is_emit;
  assign do_store = pop_o && (cmd_i.op == OP_STORE);
  assign do_left  = pop_o && (cmd_i.op == OP_LEFT);

  always_ff @(posedge clk_i) begin
    if (do_store && !cmd_i.bank_odd) begin
      bank_even_q[addr_i] <= cmd_i.cost;
    end
    if (do_emit) begin
      tl_q <= bank_even_q[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store && cmd_i.bank_odd) begin
      bank_odd_q[addr_i] <= cmd_i.cost;
    end
    if (do_emit) begin
      tr_q <= bank_odd_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (do_left) begin
      left_q <= cmd_i.cost;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      bl_q    <= left_q;
      br_q    <= cmd_i.cost;
      s1_re_q <= cmd_i.row_end;
      s1_fe_q <= cmd_i.frame_end;
    end
    if (out_free && s1_v_q) begin
      cost_q <= window_cost(tl_q, tr_q, bl_q, br_q, codes_i);
      re_q   <= s1_re_q;
      fe_q   <= s1_fe_q;
    end
  end

  assign s1_v_d  = do_emit || (s1_v_q && !out_free);
  assign out_v_d = out_free ? s1_v_q : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign down_cost_o = cost_q;
  assign row_end_o   = re_q;
  assign frame_end_o = fe_q;

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for occupancy_grid_half_scale, 2x2 window downsampling
// of a raster-order cost grid, with randomized bursts, stalls and register settings.
// depends on ogh_pkg and the occupancy_grid_half_scale rtl
module tb import ogh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridMaxWidth = MaxWidthDefault;
  // cycles allowed after the last expected result before a register write or the end
  localparam int LatencyPad   = 8;
  // register index that maps to no register
  localparam logic [2:0] CfgNoReg = 3'd7;
  // pacing modes of both sides
  localparam int PaceNone  = 0;
  localparam int PaceLight = 1;
  localparam int PaceHeavy = 2;

  typedef struct {
    logic [7:0] cost;
    logic       row_end;
    logic       frame_end;
  } down_cell_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  cell_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  down_cost_o;
  logic        row_end_o;
  logic        frame_end_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // cells waiting for the driver, and output cells the grid must still produce
  logic [7:0]  cells_to_send[$];
  down_cell_t  pending_down_cells[$];

  // shadow of the block: registers, line buffer, counters and left cell
  logic [12:0] grid_width_r;
  logic [15:0] grid_height_r;
  logic [7:0]  lethal_r;
  logic [7:0]  free_r;
  logic [7:0]  unknown_r;
  logic [7:0]  even_row_cells[GridMaxWidth];
  int unsigned col_at;
  int unsigned row_at;
  logic [7:0]  left_cell_r;

  // pacing knobs, set by the sequence while both sides are idle
  int gap_max;
  int stall_max;
  int open_max;
  int burst_left;
  int gap_left;
  int stall_run;
  logic stalling;
  logic sent;

  int errors;
  int results_seen;

  occupancy_grid_half_scale dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cell_in_i   (cell_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .down_cost_o (down_cost_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // width saturates to 2..max, height below 2 acts as 2
  function automatic int unsigned eff_width();
    int unsigned w;
    w = grid_width_r;
    if (w < 2) w = 2;
    if (w > GridMaxWidth) w = GridMaxWidth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = grid_height_r;
    if (h < 2) h = 2;
    return h;
  endfunction

  // lethal beats free beats all-unknown, else top-left wins
  function automatic logic [7:0] merge_window(input logic [7:0] tl, input logic [7:0] tr,
                                              input logic [7:0] bl, input logic [7:0] br);
    if (tl == lethal_r || tr == lethal_r || bl == lethal_r || br == lethal_r) return lethal_r;
    if (tl == free_r || tr == free_r || bl == free_r || br == free_r) return free_r;
    if (tl == unknown_r && tr == unknown_r && bl == unknown_r && br == unknown_r)
      return unknown_r;
    return tl;
  endfunction

  // advance the shadow by one transferred cell, queueing the output cell it completes
  function automatic void half_scale_step(input logic [7:0] cell_v);
    int unsigned w;
    int unsigned h;
    int unsigned last_col;
    int unsigned last_row;
    logic        line_end;
    logic        frame_last;
    down_cell_t  d;
    w = eff_width();
    h = eff_height();
    line_end   = col_at >= w - 1;
    frame_last = row_at >= h - 1;
    if (row_at[0] == 1'b0) begin
      if (col_at < GridMaxWidth) even_row_cells[col_at] = cell_v;
    end else if (col_at[0] == 1'b0) begin
      left_cell_r = cell_v;
    end else if (col_at < w) begin
      last_col = (w & ~32'd1) - 1;
      last_row = (h & ~32'd1) - 1;
      d.cost = merge_window(even_row_cells[(col_at - 1) % GridMaxWidth],
                            even_row_cells[col_at % GridMaxWidth], left_cell_r, cell_v);
      d.row_end   = col_at == last_col;
      d.frame_end = d.row_end && row_at == last_row;
      pending_down_cells.insert(pending_down_cells.size(), d);
    end
    if (line_end) begin
      col_at = 0;
      row_at = frame_last ? 0 : ((row_at + 1) & 32'hFFFF);
    end else begin
      col_at = col_at + 1;
    end
  endfunction

  // cells left until the counters wrap to the top-left corner, a whole frame from there
  function automatic int cells_to_frame_end();
    int unsigned c;
    int unsigned r;
    int n;
    c = col_at;
    r = row_at;
    n = 0;
    do begin
      n++;
      if (c >= eff_width() - 1) begin
        c = 0;
        r = (r >= eff_height() - 1) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (c != 0 || r != 0);
    return n;
  endfunction

  // cell values lean on the three codes so every window rule fires often
  function automatic logic [7:0] pick_cell();
    case ($urandom_range(0, 9))
      0, 1, 2: return lethal_r;
      3, 4:    return free_r;
      5, 6, 7: return unknown_r;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= 10) $display("mismatch %0d at %0t: %s", errors, $time, what);
  endfunction

  // sender: bursts of random length separated by random gaps, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cell_in_i  <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      sent = in_valid_i && !in_stall_o;
      if (sent) begin
        half_scale_step(cell_in_i);
        burst_left--;
        if (burst_left == 0) begin
          gap_left   = $urandom_range(0, gap_max);
          burst_left = $urandom_range(1, 24);
        end
      end
      if (in_valid_i && !sent) begin
        // stalled transfer keeps valid and payload
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
        cell_in_i  <= 8'($urandom);
      end else if (cells_to_send.size() > 0) begin
        in_valid_i <= 1'b1;
        cell_in_i  <= cells_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: checks each output transfer, stalls in alternating runs of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
      stalling  = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_down_cells.size() == 0) begin
          flag_error($sformatf("output cell %0d with nothing expected: cost %02h %b %b",
                               results_seen, down_cost_o, row_end_o, frame_end_o));
        end else begin
          down_cell_t want;
          want = pending_down_cells.pop_front();
          if (down_cost_o !== want.cost || row_end_o !== want.row_end ||
              frame_end_o !== want.frame_end)
            flag_error($sformatf({"output cell %0d: expected cost %02h row_end %b ",
                                  "frame_end %b, got %02h %b %b"}, results_seen,
                                 want.cost, want.row_end, want.frame_end,
                                 down_cost_o, row_end_o, frame_end_o));
        end
      end
      if (stall_run > 0) begin
        stall_run--;
      end else begin
        stalling  = (stall_max > 0) ? !stalling : 1'b0;
        stall_run = stalling ? $urandom_range(0, stall_max - 1) : $urandom_range(0, open_max);
      end
      out_stall_i <= stalling;
    end
  end

  // one register write transfer, mirrored into the shadow when it lands
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGridWidth:   grid_width_r  = data[12:0];
      CfgGridHeight:  grid_height_r = data;
      CfgLethalCode:  lethal_r      = data[7:0];
      CfgFreeCode:    free_r        = data[7:0];
      CfgUnknownCode: unknown_r     = data[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every cell went in and every output cell came out, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (cells_to_send.size() > 0 || in_valid_i || pending_down_cells.size() > 0);
    repeat (LatencyPad) @(negedge clk_i);
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      PaceNone: begin
        gap_max = 0; stall_max = 0; open_max = 4;
      end
      PaceLight: begin
        gap_max = 3; stall_max = 4; open_max = 8;
      end
      default: begin
        gap_max = 20; stall_max = 30; open_max = 6;
      end
    endcase
  endtask

  task automatic send_random(input int n);
    repeat (n) cells_to_send.insert(cells_to_send.size(), pick_cell());
    drain();
  endtask

  task automatic random_codes();
    logic [7:0] l;
    logic [7:0] f;
    logic [7:0] u;
    l = 8'($urandom);
    f = 8'($urandom);
    u = 8'($urandom);
    // sometimes two codes coincide, rule order then decides
    case ($urandom_range(0, 4))
      0: f = u;
      1: l = f;
      default: ;
    endcase
    write_reg(CfgLethalCode, {8'($urandom), l});
    write_reg(CfgFreeCode, {8'($urandom), f});
    write_reg(CfgUnknownCode, {8'($urandom), u});
  endtask

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int n;
    int random_sent;
    int w;
    int h;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    errors        = 0;
    results_seen  = 0;
    grid_width_r  = 13'd4096;
    grid_height_r = 16'd4096;
    lethal_r      = 8'd254;
    free_r        = 8'd0;
    unknown_r     = 8'd255;
    col_at        = 0;
    row_at        = 0;
    left_cell_r   = '0;
    foreach (even_row_cells[i]) even_row_cells[i] = '0;
    set_pace(PaceNone);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset codes, 8x3 grid: lethal, all unknown, top-left and free windows, odd row dropped
    write_reg(CfgGridWidth, 16'd8);
    write_reg(CfgGridHeight, 16'd3);
    @(negedge clk_i);
    cells_to_send = '{8'hFE, 8'h07, 8'hFF, 8'hFF, 8'h09, 8'hC8, 8'h00, 8'hFF,
                      8'h05, 8'h00, 8'hFF, 8'hFF, 8'h08, 8'h03, 8'hFF, 8'hFF,
                      8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'h40, 8'h20, 8'h10};
    drain();

    // all three codes equal, odd width drops its last column, upper data bits ignored
    write_reg(CfgGridWidth, 16'd3);
    write_reg(CfgGridHeight, 16'd2);
    write_reg(CfgLethalCode, 16'hA55A);
    write_reg(CfgFreeCode, 16'h005A);
    write_reg(CfgUnknownCode, 16'hFF5A);
    write_reg(CfgNoReg, 16'hFFFF);
    @(negedge clk_i);
    cells_to_send = '{8'h5A, 8'h01, 8'h33, 8'h02, 8'h03, 8'h44};
    drain();

    // width shrinks in mid-row: the column already past the new width ends the row
    set_pace(PaceHeavy);
    random_codes();
    write_reg(CfgGridWidth, 16'd8);
    write_reg(CfgGridHeight, 16'd4);
    send_random(5);
    write_reg(CfgGridWidth, 16'd4);
    send_random(cells_to_frame_end());

    // tallest grid, cut short: a lower height makes the current row the last one
    set_pace(PaceLight);
    write_reg(CfgGridWidth, 16'd2);
    write_reg(CfgGridHeight, 16'hFFFF);
    send_random(20);
    write_reg(CfgGridWidth, 16'd2);
    write_reg(CfgGridHeight, 16'd2);
    send_random(cells_to_frame_end());

    // widest and beyond-range width, each narrowed in mid-row, then both zero, then a width with upper bits set
    write_reg(CfgGridWidth, 16'd4096);
    write_reg(CfgGridHeight, 16'd2);
    send_random(40);
    write_reg(CfgGridWidth, 16'd8);
    send_random(cells_to_frame_end());
    write_reg(CfgGridWidth, 16'h1FFF);
    write_reg(CfgGridHeight, 16'd1);
    send_random(40);
    write_reg(CfgGridWidth, 16'd6);
    send_random(cells_to_frame_end());
    set_pace(PaceHeavy);
    write_reg(CfgGridWidth, 16'd0);
    write_reg(CfgGridHeight, 16'd0);
    send_random(cells_to_frame_end());
    write_reg(CfgGridWidth, 16'hE00A);
    write_reg(CfgGridHeight, 16'd1);
    send_random(cells_to_frame_end());

    // random phases: mostly small grids, whole frames, fresh pacing and codes per phase
    random_sent = 0;
    while (random_sent < 600) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1, 2:    w = $urandom_range(13, 40);
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 4))
        0:       h = $urandom_range(0, 1);
        default: h = (w > 12) ? $urandom_range(2, 4) : $urandom_range(2, 9);
      endcase
      set_pace($urandom_range(PaceNone, PaceHeavy));
      write_reg(CfgGridWidth, 16'(w));
      write_reg(CfgGridHeight, 16'(h));
      if ($urandom_range(0, 4) != 0) random_codes();
      n = $urandom_range(1, 3) * cells_to_frame_end();
      send_random(n);
      random_sent += n;
    end

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ogh_pkg.sv
hdl/ogh_front.sv
hdl/ogh_fifo.sv
hdl/ogh_back.sv
hdl/occupancy_grid_half_scale.sv
tb/tb.sv
